[design/tdmp_pkg.sv]
`default_nettype none

package tdmp_pkg;

   localparam int GRID_DIM_DEF = 64;
   localparam int REACH_DEF    = 3;

   localparam int FUNC_W     = 2;
   localparam int COORD_W    = 7;
   localparam int SIZE_W     = 7;
   localparam int CODE_OUT_W = 3;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_MARK  = 2'd0,
      FUNC_READ  = 2'd1,
      FUNC_CLEAR = 2'd2
   } func_type;

   typedef struct packed {
      logic valid;
      logic in_grid;
      logic last;
   } walk_type;

endpackage

`default_nettype wire

[design/tdmp_if.sv]
`default_nettype none

interface tdmp_req_if import tdmp_pkg::*;;
   logic               valid;
   logic               ready;
   logic [FUNC_W-1:0]  func;
   logic [COORD_W-1:0] row;
   logic [COORD_W-1:0] col;

   modport source (output valid, output func, output row, output col, input ready);
   modport sink   (input valid, input func, input row, input col, output ready);
endinterface

interface tdmp_rsp_if import tdmp_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [CODE_OUT_W-1:0] cell_code;
   logic                  coord_error;

   modport source (output valid, output cell_code, output coord_error, input ready);
   modport sink   (input valid, input cell_code, input coord_error, output ready);
endinterface

`default_nettype wire

[design/tdmp_ram.sv]
`default_nettype none

module tdmp_ram #(
   parameter int WIDTH = 3,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[design/tdmp_walk.sv]
`default_nettype none

module tdmp_walk import tdmp_pkg::*; #(
   parameter int GRID_DIM = GRID_DIM_DEF,
   parameter int REACH    = REACH_DEF,
   localparam int IDX_W   = $clog2(GRID_DIM),
   localparam int ADDR_W  = 2 * IDX_W,
   localparam int CODE_W  = $clog2(REACH + 2)
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [COORD_W-1:0] r0,
   input  wire logic [COORD_W-1:0] c0,
   input  wire logic [SIZE_W-1:0]  size,
   output walk_type                walk,
   output logic      [ADDR_W-1:0]  addr,
   output logic      [CODE_W-1:0]  code
);

   localparam int OFS_W = $clog2(REACH + 1) + 1;
   localparam int POS_W = COORD_W + 2;
   localparam logic signed [OFS_W-1:0] R_S = OFS_W'(REACH);

   logic                    active_ff, active_in;
   logic signed [OFS_W-1:0] dr_ff, dr_in;
   logic signed [OFS_W-1:0] dc_ff, dc_in;

   logic signed [OFS_W-1:0] dr_abs, dc_abs, dr_nx, dr_nx_abs, span;
   logic signed [POS_W-1:0] r_pos, c_pos, n_pos;
   logic                    row_end, is_last;

   always_comb begin
      dr_abs    = dr_ff[OFS_W-1] ? -dr_ff : dr_ff;
      dc_abs    = dc_ff[OFS_W-1] ? -dc_ff : dc_ff;
      span      = R_S - dr_abs;
      row_end   = (dc_ff == span);
      is_last   = row_end && (dr_ff == R_S);
      dr_nx     = dr_ff + OFS_W'(1);
      dr_nx_abs = dr_nx[OFS_W-1] ? -dr_nx : dr_nx;

      active_in = active_ff && !is_last;
      dr_in     = dr_ff;
      dc_in     = dc_ff;
      if (start) begin
         active_in = 1'b1;
         dr_in     = -R_S;
         dc_in     = '0;
      end else if (active_ff) begin
         if (row_end) begin
            dr_in = dr_nx;
            dc_in = dr_nx_abs - R_S;
         end else begin
            dc_in = dc_ff + OFS_W'(1);
         end
      end

      n_pos = $signed({2'b00, size});
      r_pos = $signed({2'b00, r0}) + POS_W'(dr_ff);
      c_pos = $signed({2'b00, c0}) + POS_W'(dc_ff);

      walk.valid   = active_ff;
      walk.last    = is_last;
      walk.in_grid = !r_pos[POS_W-1] && (r_pos < n_pos) &&
                     !c_pos[POS_W-1] && (c_pos < n_pos);
      addr = {r_pos[IDX_W-1:0], c_pos[IDX_W-1:0]};
      code = CODE_W'(dr_abs) + CODE_W'(dc_abs) + CODE_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
      dr_ff <= dr_in;
      dc_ff <= dc_in;
   end

endmodule

`default_nettype wire

[design/truncated_distance_map_painter_unit.sv]
`default_nettype none

// Grid of cell codes with a truncated Manhattan distance painter. A mark
// word walks the diamond of 2*REACH*(REACH+1)+1 cells around the point, one
// read-modify-write of the grid RAM per cycle; the RAM has a single write
// port. A clear word, and reset, run a clearing pass of one cell per cycle
// over all 2**(2*clog2(GRID_DIM)) cells of the RAM (4096 at GRID_DIM 64),
// during which no word is taken. Each word gets one response word; the next
// request is taken while that response waits.

module truncated_distance_map_painter_unit import tdmp_pkg::*; #(
   parameter int GRID_DIM = GRID_DIM_DEF,
   parameter int REACH    = REACH_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   tdmp_req_if.sink               req_bus,
   tdmp_rsp_if.source             rsp_bus,
   input  wire logic              csr_wr_en,
   input  wire logic [SIZE_W-1:0] csr_wr_data
);

   localparam int IDX_W  = $clog2(GRID_DIM);
   localparam int ADDR_W = 2 * IDX_W;
   localparam int CODE_W = $clog2(REACH + 2);
   localparam int DEPTH  = 1 << ADDR_W;

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_PAINT, ST_DRAIN, ST_READ, ST_FETCH, ST_DONE
   } state_type;

   state_type             state_ff, state_in;
   logic [SIZE_W-1:0]     grid_size_ff, grid_size_in;
   logic [ADDR_W-1:0]     clr_cnt_ff, clr_cnt_in;
   logic                  clr_reply_ff, clr_reply_in;
   logic [COORD_W-1:0]    r0_ff, r0_in, c0_ff, c0_in;
   logic                  pend_ff, pend_in;
   logic [ADDR_W-1:0]     pend_addr_ff, pend_addr_in;
   logic [CODE_W-1:0]     pend_code_ff, pend_code_in;
   logic [CODE_OUT_W-1:0] res_code_ff, res_code_in;
   logic                  res_err_ff, res_err_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CODE_OUT_W-1:0] rsp_code_ff, rsp_code_in;
   logic                  rsp_err_ff, rsp_err_in;

   logic [SIZE_W-1:0] eff_size;
   logic              bad, accept, walk_start, ram_we;
   logic [ADDR_W-1:0] ram_wa, ram_ra, walk_addr;
   logic [CODE_W-1:0] ram_wd, ram_rd, walk_code;
   walk_type          walk;

   tdmp_walk #(.GRID_DIM(GRID_DIM), .REACH(REACH)) u_walk (
      .clock (clock),
      .reset (reset),
      .start (walk_start),
      .r0    (r0_ff),
      .c0    (c0_ff),
      .size  (eff_size),
      .walk  (walk),
      .addr  (walk_addr),
      .code  (walk_code)
   );

   tdmp_ram #(.WIDTH(CODE_W), .DEPTH(DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   assign req_bus.ready       = (state_ff == ST_IDLE);
   assign accept              = req_bus.valid && req_bus.ready;
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.cell_code   = rsp_code_ff;
   assign rsp_bus.coord_error = rsp_err_ff;

   always_comb begin
      eff_size = (int'(grid_size_ff) > GRID_DIM) ? SIZE_W'(GRID_DIM) : grid_size_ff;
      bad = (req_bus.row == '0) || (req_bus.row > eff_size) ||
            (req_bus.col == '0) || (req_bus.col > eff_size);

      ram_ra = (state_ff == ST_READ) ? {r0_ff[IDX_W-1:0], c0_ff[IDX_W-1:0]} : walk_addr;
      if (state_ff == ST_CLEAR) begin
         ram_we = 1'b1;
         ram_wa = clr_cnt_ff;
         ram_wd = '0;
      end else begin
         ram_we = pend_ff && ((ram_rd == '0) || (ram_rd > pend_code_ff));
         ram_wa = pend_addr_ff;
         ram_wd = pend_code_ff;
      end

      pend_in      = walk.valid && walk.in_grid;
      pend_addr_in = walk_addr;
      pend_code_in = walk_code;

      state_in     = state_ff;
      grid_size_in = csr_wr_en ? csr_wr_data : grid_size_ff;
      clr_cnt_in   = clr_cnt_ff;
      clr_reply_in = clr_reply_ff;
      r0_in        = r0_ff;
      c0_in        = c0_ff;
      res_code_in  = res_code_ff;
      res_err_in   = res_err_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_code_in  = rsp_code_ff;
      rsp_err_in   = rsp_err_ff;
      walk_start   = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + ADDR_W'(1);
            if (&clr_cnt_ff) begin
               state_in = clr_reply_ff ? ST_DONE : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               r0_in       = req_bus.row - COORD_W'(1);
               c0_in       = req_bus.col - COORD_W'(1);
               res_code_in = '0;
               res_err_in  = 1'b0;
               unique case (func_type'(req_bus.func))
                  FUNC_MARK: begin
                     res_err_in = bad;
                     state_in   = bad ? ST_DONE : ST_PAINT;
                     walk_start = !bad;
                  end
                  FUNC_READ: begin
                     res_err_in = bad;
                     state_in   = bad ? ST_DONE : ST_READ;
                  end
                  FUNC_CLEAR: begin
                     clr_cnt_in   = '0;
                     clr_reply_in = 1'b1;
                     state_in     = ST_CLEAR;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_PAINT: begin
            if (walk.valid && walk.last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_READ: begin
            state_in = ST_FETCH;
         end
         ST_FETCH: begin
            res_code_in = CODE_OUT_W'(ram_rd);
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_code_in  = res_code_ff;
               rsp_err_in   = res_err_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         grid_size_ff <= SIZE_RESET;
         clr_cnt_ff   <= '0;
         clr_reply_ff <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         grid_size_ff <= grid_size_in;
         clr_cnt_ff   <= clr_cnt_in;
         clr_reply_ff <= clr_reply_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      r0_ff        <= r0_in;
      c0_ff        <= c0_in;
      pend_addr_ff <= pend_addr_in;
      pend_code_ff <= pend_code_in;
      res_code_ff  <= res_code_in;
      res_err_ff   <= res_err_in;
      rsp_code_ff  <= rsp_code_in;
      rsp_err_ff   <= rsp_err_in;
   end

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff != ST_IDLE && state_ff != ST_DONE))
      else $error("grid written outside a mark or clear");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != ST_IDLE))
      else $error("accepted word did not start work");

   a_pend_code_nonzero: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (pend_code_ff != '0))
      else $error("paint update with zero code");

   a_err_code_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_err_ff) |-> (rsp_code_ff == '0))
      else $error("coordinate error response carries a code");

   a_paint_walker: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PAINT) |-> walk.valid)
      else $error("paint state without walker activity");

endmodule

`default_nettype wire
